>>> hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_store and lru_key_value_cache; no dependencies.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] SET_VALUE  = '0;

    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic
    {
        KIND_GET = 1'b0,
        KIND_SET = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed
    {
        logic              hit;
        logic [DATA_W-1:0] rd;
    } resp_t;

endpackage

>>> hw/rtl/lru_key_value_cache.sv
// LRU key-value cache top level: input and result registers, capacity
// register and the assertions. Depends on lkvc_pkg and lkvc_store.
//
// Usage:
//   s_*   request stream. tuser is the kind (0 get, 1 set); tdata carries
//         key in bits 31:0 and value in bits 63:32.
//   m_*   result stream, one transfer per request. tuser is the hit flag;
//         tdata is the read value: stored value on a get hit, all ones on a
//         get miss, zero for every set.
//   cfg_* capacity write (5 bits); take it only while no request is in flight.
// Timing:
//   A request is registered on transfer and looked up in the following cycle;
//   the store update and the result register load together once the result
//   register is free or being drained, and m_tvalid then rises. One request
//   per cycle is sustained while m_tready stays high;
//   the parallel key compare and rank update sit between the two registers.
// Reset:
//   The store starts empty, capacity returns to 16 and both streams go idle.
// Stall:
//   While m_tready is low the result is held; one further request is taken
//   into the input register, then s_tready drops until the result moves.
module lru_key_value_cache
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // key[31:0], value[63:32]
    input  logic                        s_tuser,   // kind[0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // read_value[31:0]
    output logic                        m_tuser,   // hit[0]
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data
);
    import lkvc_pkg::*;

    logic              in_valid_reg;
    req_t              in_req_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_rd_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic              advance;
    resp_t             resp;
    count_t            entry_count;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg.kind  <= kind_t'(s_tuser);
            in_req_reg.key   <= s_tdata[31:0];
            in_req_reg.value <= s_tdata[63:32];
        end
        if (advance)
        begin
            out_hit_reg <= resp.hit;
            out_rd_reg  <= resp.rd;
        end
    end

    lkvc_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .apply       (advance),
        .req         (in_req_reg),
        .resp        (resp),
        .entry_count (entry_count)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rd_reg;
    assign m_tuser  = out_hit_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(entry_count) <= ENTRIES)
        else $error("entry count above store size");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (entry_count >= $past(entry_count)))
        else $error("entry count decreased");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_req_reg.kind == KIND_GET) && !resp.hit)
        |=> (m_tvalid && !m_tuser && (m_tdata == MISS_VALUE)))
        else $error("get miss did not return the miss value");

    a_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_req_reg.kind == KIND_SET)) |=> (m_tdata == SET_VALUE))
        else $error("set returned a non-zero read value");
`endif

endmodule

>>> hw/rtl/lkvc_store.sv
// Entry store of the LRU key-value cache: keys, values, valid bits and ranks,
// with the parallel lookup and the replacement update. Depends on lkvc_pkg.
module lkvc_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lkvc_pkg::CAP_W-1:0]   capacity,
    input  logic                         apply,
    input  lkvc_pkg::req_t               req,
    output lkvc_pkg::resp_t              resp,
    output lkvc_pkg::count_t             entry_count
);
    import lkvc_pkg::*;

    logic  [ENTRIES-1:0]             valid_reg;
    logic  [ENTRIES-1:0]             valid_next;
    rank_t                           rank_reg   [ENTRIES];
    rank_t                           rank_next  [ENTRIES];
    logic  [KEY_W-1:0]               key_reg    [ENTRIES];
    logic  [DATA_W-1:0]              value_reg  [ENTRIES];
    count_t                          count_reg;
    count_t                          count_next;

    logic  [ENTRIES-1:0]             match;
    logic  [ENTRIES-1:0]             free_oh;
    logic  [ENTRIES-1:0]             oldest_oh;
    logic  [ENTRIES-1:0]             slot_oh;
    logic  [ENTRIES-1:0]             key_wr;
    logic  [ENTRIES-1:0]             val_wr;
    logic                            hit;
    logic                            has_room;
    rank_t                           hit_rank;
    logic  [DATA_W-1:0]              hit_value;
    count_t                          limit;

    // Clamp the capacity to 1..ENTRIES
    always_comb
    begin
        if (capacity == '0)
            limit = count_t'(1);
        else if (32'(capacity) > ENTRIES)
            limit = count_t'(ENTRIES);
        else
            limit = count_t'(capacity);
    end

    // Keys are unique among valid entries, so the match vector is at most one-hot
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (key_reg[i] == req.key);
            oldest_oh[i] = valid_reg[i] && ((32'(rank_reg[i]) + 1) == 32'(count_reg));
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
        end
        hit      = |match;
        free_oh  = ~valid_reg & (valid_reg + ENTRIES'(1));
        has_room = (count_reg < limit);
        slot_oh  = has_room ? free_oh : oldest_oh;
    end

    always_comb
    begin
        resp.hit = hit;
        if (req.kind == KIND_SET)
            resp.rd = SET_VALUE;
        else if (hit)
            resp.rd = hit_value;
        else
            resp.rd = MISS_VALUE;
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        key_wr     = '0;
        val_wr     = '0;
        if (apply)
        begin
            if (hit)
            begin
                // Promote: more recent entries slide down by one
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        rank_next[i] = rank_reg[i] + rank_t'(1);
                    if (match[i])
                        rank_next[i] = '0;
                end
                if (req.kind == KIND_SET)
                    val_wr = match;
            end
            else if (req.kind == KIND_SET)
            begin
                // Insert at rank 0, replacing the oldest entry when full
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i])
                        rank_next[i] = rank_reg[i] + rank_t'(1);
                    if (slot_oh[i])
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                end
                key_wr = slot_oh;
                val_wr = slot_oh;
                if (has_room)
                    count_next = count_reg + count_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (key_wr[i])
                key_reg[i] <= req.key;
            if (val_wr[i])
                value_reg[i] <= req.value;
        end
    end

    assign entry_count = count_reg;

endmodule
